[hdl/assert_macros.svh]
// Assertion macros for the sequencer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

[hdl/ssq_pkg.sv]
// Types and constants of the step sequencer square-wave synth
package ssq_pkg;

    localparam int MAX_ROWS = 6;

    typedef logic [15:0]        t_phase;
    typedef logic [15:0]        t_pattern;
    typedef logic [12:0]        t_count;
    typedef logic [3:0]         t_step;
    typedef logic signed [14:0] t_sample;
    typedef logic signed [3:0]  t_diff;
    typedef logic [2:0]         t_reg_idx;

    // Note increments per tick, row 0 first
    localparam t_phase ROW_FREQ [MAX_ROWS] = '{
        16'd330, 16'd294, 16'd261, 16'd220, 16'd196, 16'd147
    };

    localparam t_phase      SAMPLE_RATE = 16'd44100;
    localparam t_phase      HALF_RATE   = 16'd22050;
    localparam logic [13:0] ENV_LEN     = 14'd12000;
    localparam t_count      SPS_RESET   = 13'd5512;
    localparam t_sample     SAMPLE_MAX  = 15'sd9000;
    localparam t_sample     SAMPLE_MIN  = -15'sd9000;

    // Register map, one 32-bit word each
    localparam t_reg_idx REG_ROW0 = 3'd0;
    localparam t_reg_idx REG_ROW1 = 3'd1;
    localparam t_reg_idx REG_ROW2 = 3'd2;
    localparam t_reg_idx REG_ROW3 = 3'd3;
    localparam t_reg_idx REG_ROW4 = 3'd4;
    localparam t_reg_idx REG_ROW5 = 3'd5;
    localparam t_reg_idx REG_SPS  = 3'd6;

    // Per-tick request to the mixer
    typedef struct packed {
        logic [MAX_ROWS-1:0] row_on;
        t_count              n;
    } t_mix_ctl;

endpackage

[hdl/ssq_if.sv]
// Tick and sample channel interfaces

interface ssq_in_if;
    logic valid;
    logic ready;
    logic last_in_block;

    modport source (output valid, output last_in_block, input ready);
    modport sink   (input valid, input last_in_block, output ready);
endinterface

interface ssq_out_if;
    logic             valid;
    logic             ready;
    ssq_pkg::t_sample sample;
    ssq_pkg::t_step   current_step;
    logic             step_advanced;
    logic             block_last;

    modport source (output valid, output sample, output current_step,
                    output step_advanced, output block_last, input ready);
    modport sink   (input valid, input sample, input current_step,
                    input step_advanced, input block_last, output ready);
endinterface

[hdl/ssq_mixer.sv]
// Square-wave mixer: row vote times decaying envelope, divided by 8
module ssq_mixer #(
    parameter int ROWS = 6
) (
    input  ssq_pkg::t_mix_ctl         i_ctl,
    input  ssq_pkg::t_phase [ROWS-1:0] i_phase,
    output ssq_pkg::t_sample          o_sample
);

    logic [2:0]         w_hi;
    logic [2:0]         w_lo;
    ssq_pkg::t_diff     w_diff;
    logic [13:0]        w_env;
    logic signed [18:0] w_prod;
    logic signed [18:0] w_bias;
    logic signed [18:0] w_quot;

    always_comb begin
        w_hi = '0;
        w_lo = '0;
        for (int r = 0; r < ROWS; r++) begin
            if (i_ctl.row_on[r]) begin
                if (i_phase[r] < ssq_pkg::HALF_RATE) begin
                    w_hi = w_hi + 3'd1;
                end else begin
                    w_lo = w_lo + 3'd1;
                end
            end
        end
    end

    assign w_diff = signed'({1'b0, w_hi}) - signed'({1'b0, w_lo});

    // n never reaches the envelope end in practice; kept for completeness
    assign w_env = ({1'b0, i_ctl.n} < ssq_pkg::ENV_LEN)
                 ? ssq_pkg::ENV_LEN - {1'b0, i_ctl.n} : 14'd0;

    assign w_prod = 19'(w_diff) * 19'(signed'({1'b0, w_env}));

    // truncate toward zero
    assign w_bias = w_prod + (w_prod[18] ? 19'sd7 : 19'sd0);
    assign w_quot = w_bias >>> 3;

    assign o_sample = ssq_pkg::t_sample'(w_quot[14:0]);

endmodule

[hdl/step_sequencer_square_synth.sv]
// Step sequencer square-wave synth top level with APB register file
//
//  channel  dir  handshake         payload
//  i_in     in   valid/ready       last_in_block
//  o_out    out  valid/ready       sample, current_step, step_advanced, block_last
//  apb      in   psel/penable      paddr, pwdata -> prdata (pready tied high)
//
// One tick per cycle while the output register is free; the result appears in the cycle after its transfer.
// The only stage is the output register; ticks keep flowing while it is
// empty or being taken in the same cycle.
// Synchronous active-low reset: step, sample count and phases go to zero,
// patterns to zero, step length to 5512 ticks.
module step_sequencer_square_synth #(
    parameter int STEPS = 16,
    parameter int ROWS  = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ssq_in_if.sink              i_in,
    ssq_out_if.source           o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    `include "assert_macros.svh"

    localparam ssq_pkg::t_step STEP_LAST = 4'(STEPS - 1);

    ssq_pkg::t_pattern r_pattern [ssq_pkg::MAX_ROWS];
    ssq_pkg::t_count   r_sps;
    ssq_pkg::t_step    r_step;
    ssq_pkg::t_count   r_n;
    ssq_pkg::t_phase [ROWS-1:0] r_phase;

    logic              r_out_valid;
    ssq_pkg::t_sample  r_sample;
    ssq_pkg::t_step    r_cur;
    logic              r_adv;
    logic              r_last;

    logic              w_in_ready;
    logic              w_in_fire;
    logic              w_cfg_wr;
    ssq_pkg::t_reg_idx w_idx;
    logic [13:0]       w_next_n;
    logic              w_adv;
    ssq_pkg::t_step    n_step;
    ssq_pkg::t_mix_ctl w_ctl;
    ssq_pkg::t_sample  w_sample;
    ssq_pkg::t_phase [ROWS-1:0] n_phase;

    // ---------------- register file ----------------
    assign pready   = 1'b1;
    assign w_idx    = paddr[4:2];
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ssq_pkg::MAX_ROWS; r++) begin
                r_pattern[r] <= '0;
            end
            r_sps <= ssq_pkg::SPS_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                ssq_pkg::REG_ROW0: r_pattern[0] <= pwdata[15:0];
                ssq_pkg::REG_ROW1: r_pattern[1] <= pwdata[15:0];
                ssq_pkg::REG_ROW2: r_pattern[2] <= pwdata[15:0];
                ssq_pkg::REG_ROW3: r_pattern[3] <= pwdata[15:0];
                ssq_pkg::REG_ROW4: r_pattern[4] <= pwdata[15:0];
                ssq_pkg::REG_ROW5: r_pattern[5] <= pwdata[15:0];
                ssq_pkg::REG_SPS:  r_sps        <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            ssq_pkg::REG_ROW0: prdata = {16'd0, r_pattern[0]};
            ssq_pkg::REG_ROW1: prdata = {16'd0, r_pattern[1]};
            ssq_pkg::REG_ROW2: prdata = {16'd0, r_pattern[2]};
            ssq_pkg::REG_ROW3: prdata = {16'd0, r_pattern[3]};
            ssq_pkg::REG_ROW4: prdata = {16'd0, r_pattern[4]};
            ssq_pkg::REG_ROW5: prdata = {16'd0, r_pattern[5]};
            ssq_pkg::REG_SPS:  prdata = {19'd0, r_sps};
            default:           prdata = '0;
        endcase
    end

    // ---------------- tick datapath ----------------
    assign w_in_ready = !r_out_valid || o_out.ready;
    assign w_in_fire  = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    // zero tempo behaves as one: compare is >= against the raw register
    assign w_next_n = {1'b0, r_n} + 14'd1;
    assign w_adv    = w_next_n >= {1'b0, r_sps};
    assign n_step   = (r_step == STEP_LAST) ? '0 : r_step + 4'd1;

    always_comb begin
        for (int r = 0; r < ssq_pkg::MAX_ROWS; r++) begin
            w_ctl.row_on[r] = r_pattern[r][r_step];
        end
        w_ctl.n = r_n;
    end

    ssq_mixer #(
        .ROWS (ROWS)
    ) u_mixer (
        .i_ctl    (w_ctl),
        .i_phase  (r_phase),
        .o_sample (w_sample)
    );

    // phase accumulators, modulo the sample rate by one conditional subtract
    always_comb begin
        logic [16:0] sum;
        for (int r = 0; r < ROWS; r++) begin
            sum = {1'b0, r_phase[r]} + {1'b0, ssq_pkg::ROW_FREQ[r]};
            if (sum >= {1'b0, ssq_pkg::SAMPLE_RATE}) begin
                n_phase[r] = 16'(sum - {1'b0, ssq_pkg::SAMPLE_RATE});
            end else begin
                n_phase[r] = sum[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_n         <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                if (w_adv) begin
                    r_step  <= n_step;
                    r_n     <= '0;
                    r_phase <= '0;
                end else begin
                    r_n     <= w_next_n[12:0];
                    r_phase <= n_phase;
                end
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_sample <= w_sample;
            r_cur    <= r_step;
            r_adv    <= w_adv;
            r_last   <= i_in.last_in_block;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.sample        = r_sample;
    assign o_out.current_step  = r_cur;
    assign o_out.step_advanced = r_adv;
    assign o_out.block_last    = r_last;

    // ---------------- assertions ----------------
    `ASSERT_CLK(a_adv_clears_count, w_in_fire && w_adv |=> r_n == '0,
        "sample count not cleared on step advance")
    `ASSERT_CLK(a_hold_step, w_in_fire && !w_adv |=> r_step == $past(r_step),
        "step moved without advance")
    `ASSERT_CLK(a_step_range, r_step <= STEP_LAST, "step index past last step")
    `ASSERT_CLK(a_sample_range,
        r_out_valid |-> (r_sample <= ssq_pkg::SAMPLE_MAX && r_sample >= ssq_pkg::SAMPLE_MIN),
        "sample out of range")

    for (genvar g = 0; g < ROWS; g++) begin : g_phase_chk
        `ASSERT_CLK(a_phase_range, r_phase[g] < ssq_pkg::SAMPLE_RATE,
            "phase accumulator past sample rate")
    end

endmodule
